[hw/rtl/rma_pkg.sv]
// shared constants, types and register codes for the row-major array store
package rma_pkg;

   localparam int MAX_DIMS    = 4;
   localparam int NUM_IDX     = 4;
   localparam int DIMS_CAP    = (MAX_DIMS < NUM_IDX) ? MAX_DIMS : NUM_IDX;
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = 10;
   localparam int IDX_W       = 10;
   localparam int BOUND_W     = 11;
   localparam int DATA_W      = 32;
   localparam int NDIMS_W     = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int DIM_W       = $clog2(NUM_IDX);
   localparam int CNT_W       = $clog2(BOUND_W);
   localparam int PROD_W      = ADDR_W + BOUND_W;
   localparam int SUM_W       = PROD_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIMS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_3  = 3'd4;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef logic [NUM_IDX-1:0][IDX_W-1:0]   idx_vec_type;
   typedef logic [NUM_IDX-1:0][BOUND_W-1:0] bound_vec_type;

   typedef struct packed {
      logic              done;
      logic              err;
      logic [ADDR_W-1:0] offset;
   } ofs_result_type;

endpackage

[hw/rtl/row_major_array_access.sv]
// an accepted request passes through the offset unit (T_CALC), the store access (T_MEM) and the output
// register to rsp_valid; req_stall holds off the next request until the response is in the output register,
//   and the offset multiply is bit-serial (one bound bit per cycle per dimension after the first)
// a new request is taken while the previous response still waits in the output register
// reset (synchronous): control cleared, num_dims = 1, every bound = 1; the store is not cleared
module row_major_array_access (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [rma_pkg::IDX_W-1:0]           req_idx_0,
   input  logic [rma_pkg::IDX_W-1:0]           req_idx_1,
   input  logic [rma_pkg::IDX_W-1:0]           req_idx_2,
   input  logic [rma_pkg::IDX_W-1:0]           req_idx_3,
   input  logic signed [rma_pkg::DATA_W-1:0]   req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rma_pkg::DATA_W-1:0]   rsp_read_data,
   output logic [rma_pkg::ADDR_W-1:0]          rsp_linear_offset,
   output logic                                rsp_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rma_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rma_pkg::BOUND_W-1:0]         csr_data
);
   import rma_pkg::*;

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_CALC = 3'b010,
      T_MEM  = 3'b100
   } tstate_type;

   tstate_type         state_ff, state_in;
   logic [NDIMS_W-1:0] num_dims_ff, num_dims_in;
   bound_vec_type      bounds_ff, bounds_in;
   logic               start_ff, start_in;
   logic               op_ff, op_in;
   idx_vec_type        idx_ff, idx_in;
   logic [DATA_W-1:0]  wdata_ff, wdata_in;
   logic               err_hold_ff, err_hold_in;
   logic [ADDR_W-1:0]  ofs_hold_ff, ofs_hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [ADDR_W-1:0]  rsp_ofs_ff, rsp_ofs_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               req_take;
   logic               out_free;
   logic [DIM_W-1:0]   last_dim;
   ofs_result_type     ofs;
   logic               mem_wr;
   logic               mem_rd;
   logic [DATA_W-1:0]  mem_rdata;

   assign req_stall = (state_ff != T_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // zero dimensions act as one, too many saturate
   always_comb begin
      if (num_dims_ff == '0) begin
         last_dim = '0;
      end else if (num_dims_ff > NDIMS_W'(DIMS_CAP)) begin
         last_dim = DIM_W'(DIMS_CAP - 1);
      end else begin
         last_dim = DIM_W'(num_dims_ff - 1'b1);
      end
   end

   always_comb begin
      num_dims_in = num_dims_ff;
      bounds_in   = bounds_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_DIMS: num_dims_in  = csr_data[NDIMS_W-1:0];
            CSR_BOUND_0:  bounds_in[0] = csr_data;
            CSR_BOUND_1:  bounds_in[1] = csr_data;
            CSR_BOUND_2:  bounds_in[2] = csr_data;
            CSR_BOUND_3:  bounds_in[3] = csr_data;
            default:      num_dims_in  = num_dims_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      op_in        = op_ff;
      idx_in       = idx_ff;
      wdata_in     = wdata_ff;
      err_hold_in  = err_hold_ff;
      ofs_hold_in  = ofs_hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_ofs_in   = rsp_ofs_ff;
      rsp_err_in   = rsp_err_ff;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      case (state_ff)
         T_IDLE: begin
            if (req_take) begin
               op_in    = req_op;
               idx_in   = {req_idx_3, req_idx_2, req_idx_1, req_idx_0};
               wdata_in = req_write_data;
               start_in = 1'b1;
               state_in = T_CALC;
            end
         end
         T_CALC: begin
            if (ofs.done) begin
               mem_wr      = !ofs.err && (op_ff == OP_WRITE);
               mem_rd      = !ofs.err && (op_ff == OP_READ);
               err_hold_in = ofs.err;
               ofs_hold_in = ofs.offset;
               state_in    = T_MEM;
            end
         end
         T_MEM: begin
            // read data stays in the store's output register until the next read
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_hold_ff;
               rsp_ofs_in   = err_hold_ff ? '0 : ofs_hold_ff;
               rsp_data_in  = (!err_hold_ff && (op_ff == OP_READ)) ? mem_rdata : '0;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         num_dims_ff  <= NDIMS_W'(1);
         bounds_ff    <= {NUM_IDX{BOUND_W'(1)}};
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         num_dims_ff  <= num_dims_in;
         bounds_ff    <= bounds_in;
      end
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      wdata_ff    <= wdata_in;
      err_hold_ff <= err_hold_in;
      ofs_hold_ff <= ofs_hold_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ofs_ff  <= rsp_ofs_in;
      rsp_err_ff  <= rsp_err_in;
   end

   rma_offset u_offset (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .last_dim (last_dim),
      .idx      (idx_ff),
      .bounds   (bounds_ff),
      .result   (ofs)
   );

   rma_store u_store (
      .clock (clock),
      .wr_en (mem_wr),
      .rd_en (mem_rd),
      .addr  (ofs.offset),
      .wdata (wdata_ff),
      .rdata (mem_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_linear_offset = rsp_ofs_ff;
   assign rsp_error         = rsp_err_ff;

endmodule

[hw/rtl/rma_offset.sv]
// bit-serial row-major offset unit with index and range checks
module rma_offset (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rma_pkg::DIM_W-1:0]   last_dim,
   input  rma_pkg::idx_vec_type        idx,
   input  rma_pkg::bound_vec_type      bounds,
   output rma_pkg::ofs_result_type     result
);
   import rma_pkg::*;

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_MUL  = 3'b010,
      U_DONE = 3'b100
   } ustate_type;

   ustate_type         state_ff, state_in;
   logic [DIM_W-1:0]   dim_ff, dim_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [BOUND_W-1:0] mulsr_ff, mulsr_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ADDR_W-1:0]  acc_ff, acc_in;
   logic               err_ff, err_in;

   logic [PROD_W-1:0]  prod_step;
   logic [SUM_W-1:0]   sum;
   logic [DIM_W-1:0]   next_dim;
   logic               idx_bad;
   logic               first_bad;
   logic               last_bit;

   // horner form: acc = acc * bound + idx, one bound bit per cycle, msb first
   assign prod_step = {prod_ff[PROD_W-2:0], 1'b0}
                    + (mulsr_ff[BOUND_W-1] ? PROD_W'(acc_ff) : '0);
   assign sum       = SUM_W'(prod_step) + SUM_W'(idx[dim_ff]);
   assign next_dim  = dim_ff + 1'b1;
   assign idx_bad   = BOUND_W'(idx[dim_ff]) >= bounds[dim_ff];
   assign first_bad = BOUND_W'(idx[0]) >= bounds[0];
   assign last_bit  = (cnt_ff == CNT_W'(BOUND_W - 1));

   always_comb begin
      state_in = state_ff;
      dim_in   = dim_ff;
      cnt_in   = cnt_ff;
      mulsr_in = mulsr_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               acc_in   = idx[0];
               err_in   = first_bad;
               cnt_in   = '0;
               prod_in  = '0;
               mulsr_in = bounds[1];
               dim_in   = DIM_W'(1);
               if (last_dim == '0) begin
                  state_in = U_DONE;
               end else begin
                  state_in = U_MUL;
               end
            end
         end
         U_MUL: begin
            prod_in  = prod_step;
            mulsr_in = mulsr_ff << 1;
            cnt_in   = cnt_ff + 1'b1;
            if (last_bit) begin
               // once the running offset passes the store it can only grow
               acc_in  = sum[ADDR_W-1:0];
               err_in  = err_ff | idx_bad | (sum >= SUM_W'(STORE_DEPTH));
               cnt_in  = '0;
               prod_in = '0;
               if (dim_ff == last_dim) begin
                  state_in = U_DONE;
               end else begin
                  dim_in   = next_dim;
                  mulsr_in = bounds[next_dim];
               end
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dim_ff   <= dim_in;
      cnt_ff   <= cnt_in;
      mulsr_ff <= mulsr_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      err_ff   <= err_in;
   end

   assign result.done   = (state_ff == U_DONE);
   assign result.err    = err_ff;
   assign result.offset = acc_ff;

endmodule

[hw/rtl/rma_store.sv]
// element memory, one write or one registered read per cycle
module rma_store (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [rma_pkg::ADDR_W-1:0]   addr,
   input  logic [rma_pkg::DATA_W-1:0]   wdata,
   output logic [rma_pkg::DATA_W-1:0]   rdata
);
   import rma_pkg::*;

   logic [DATA_W-1:0] mem [STORE_DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/rma_checker.sv]
// port-level checks for the row-major array store, bound to the top level
module rma_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [rma_pkg::DATA_W-1:0]   rsp_read_data,
   input logic [rma_pkg::ADDR_W-1:0]          rsp_linear_offset,
   input logic                                rsp_error
);
   import rma_pkg::*;

   // one word in flight: the input stalls right after a word is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous word still in calculation");

   // a flagged access reports no data and no offset
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_read_data == '0 && rsp_linear_offset == '0))
      else $error("error response carries data or offset");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_data)
                                    && $stable(rsp_error)))
      else $error("stalled response changed");

endmodule

bind row_major_array_access rma_checker u_rma_checker (.*);
